// File: rtl/pva_pkg.sv
package pva_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int NSTEPS       = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    // Coordinates carry 22 fraction bits; angles carry 16 fraction bits of degrees.
    localparam int CW = 36;
    localparam int ZW = 26;

    localparam logic [30:0] GAIN_Q31 = 31'd1304065748;
    localparam int          HALF_TURN   = 23040;
    localparam int          FULL_TURN   = 46080;
    localparam logic signed [ZW-1:0] QUARTER_Q16 = 26'sd5898240;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [ZW-1:0] angle_t;

    function automatic angle_t atan_deg(input int i);
        angle_t r;
        case (i)
            0: r = 26'sd2949120;   1: r = 26'sd1740967;  2: r = 26'sd919879;
            3: r = 26'sd466945;    4: r = 26'sd234379;   5: r = 26'sd117304;
            6: r = 26'sd58666;     7: r = 26'sd29335;    8: r = 26'sd14668;
            9: r = 26'sd7334;      10: r = 26'sd3667;    11: r = 26'sd1833;
            12: r = 26'sd917;      13: r = 26'sd458;     14: r = 26'sd229;
            15: r = 26'sd115;      16: r = 26'sd57;      17: r = 26'sd29;
            18: r = 26'sd14;       19: r = 26'sd7;       20: r = 26'sd4;
            21: r = 26'sd2;        22: r = 26'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/polar_vector_add_unit.sv
// Adds two polar vectors (Q8.8 radius, Q9.7 degree angle) and returns the sum as a
// Q9.8 radius and a Q9.7 angle; a zero sum reads as radius 0, angle 0. Two rotation
// CORDIC lanes work side by side, then one vectoring CORDIC merges their results.
// The pipeline takes one request per clock while the output is not stalled; the two
// CORDIC chains run in series. A stalled output freezes the whole pipeline.
module polar_vector_add_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_radius[15:0], first_angle[31:16], second_radius[47:32], second_angle[63:48]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // sum_radius[16:0], sum_angle[32:17], zero fill [39:33]
    output logic [39:0] m_tdata
);

    localparam int N     = pva_pkg::NSTEPS;
    localparam int DEPTH = 2 * N + 5;

    logic [DEPTH-1:0] valid_reg;
    logic             advance;
    logic [DEPTH-1:0] en;
    pva_pkg::coord_t  x1, y1, x2, y2;
    logic [16:0]      sum_radius;
    logic signed [15:0] sum_angle;

    assign advance  = m_tready || !m_tvalid;
    assign s_tready = advance;
    assign m_tvalid = valid_reg[DEPTH-1];

    always_comb
    begin
        en[0] = advance && s_tvalid;
        for (int i = 1; i < DEPTH; i++)
            en[i] = advance && valid_reg[i-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[DEPTH-2:0], s_tvalid};
    end

    pva_rect_lane u_lane1 (
        .clk    (clk),
        .en     (en[N+1:0]),
        .radius (s_tdata[15:0]),
        .angle  (s_tdata[31:16]),
        .x      (x1),
        .y      (y1)
    );

    pva_rect_lane u_lane2 (
        .clk    (clk),
        .en     (en[N+1:0]),
        .radius (s_tdata[47:32]),
        .angle  (s_tdata[63:48]),
        .x      (x2),
        .y      (y2)
    );

    pva_polar_merge u_merge (
        .clk        (clk),
        .en         (en[DEPTH-1:N+2]),
        .x1         (x1),
        .y1         (y1),
        .x2         (x2),
        .y2         (y2),
        .sum_radius (sum_radius),
        .sum_angle  (sum_angle)
    );

    assign m_tdata = {7'd0, sum_angle, sum_radius};

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (sum_angle <= 16'sd23040 && sum_angle >= -16'sd23040))
        else $error("sum angle out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

// File: rtl/pva_rect_lane.sv
module pva_rect_lane (
    input  logic                   clk,
    input  logic [pva_pkg::NSTEPS+1:0] en,
    input  logic [15:0]            radius,
    input  logic signed [15:0]     angle,
    output pva_pkg::coord_t        x,
    output pva_pkg::coord_t        y
);

    localparam int N = pva_pkg::NSTEPS;

    pva_pkg::coord_t x_reg [N+1];
    pva_pkg::coord_t y_reg [N+1];
    pva_pkg::angle_t z_reg [N+1];
    logic [46:0]     prod_reg;
    logic signed [17:0] ang_reg;

    logic signed [17:0] a_wrap;
    pva_pkg::coord_t    r0;
    pva_pkg::angle_t    z0;

    always_comb
    begin
        if (angle > 16'sd23040)
            a_wrap = 18'(angle) - 18'sd46080;
        else if (angle < -16'sd23040)
            a_wrap = 18'(angle) + 18'sd46080;
        else
            a_wrap = 18'(angle);
    end

    // Stage 0 prescales the radius by the CORDIC gain.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg <= 47'(radius) * 47'(pva_pkg::GAIN_Q31);
            ang_reg  <= a_wrap;
        end
    end

    always_comb
    begin
        r0 = pva_pkg::coord_t'(prod_reg[46:17]);
        z0 = pva_pkg::angle_t'(ang_reg) <<< 9;
    end

    // Stage 1 pre-rotates by a quarter turn when the angle lies beyond 90 degrees.
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            if (z0 > pva_pkg::QUARTER_Q16)
            begin
                x_reg[0] <= '0;
                y_reg[0] <= r0;
                z_reg[0] <= z0 - pva_pkg::QUARTER_Q16;
            end
            else if (z0 < -pva_pkg::QUARTER_Q16)
            begin
                x_reg[0] <= '0;
                y_reg[0] <= -r0;
                z_reg[0] <= z0 + pva_pkg::QUARTER_Q16;
            end
            else
            begin
                x_reg[0] <= r0;
                y_reg[0] <= '0;
                z_reg[0] <= z0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en[i+2])
            begin
                if (!z_reg[i][pva_pkg::ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - pva_pkg::atan_deg(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + pva_pkg::atan_deg(i);
                end
            end
        end
    end

    assign x = x_reg[N];
    assign y = y_reg[N];

endmodule

// File: rtl/pva_polar_merge.sv
module pva_polar_merge (
    input  logic                       clk,
    input  logic [pva_pkg::NSTEPS+2:0] en,
    input  pva_pkg::coord_t            x1,
    input  pva_pkg::coord_t            y1,
    input  pva_pkg::coord_t            x2,
    input  pva_pkg::coord_t            y2,
    output logic [16:0]                sum_radius,
    output logic signed [15:0]         sum_angle
);

    localparam int N = pva_pkg::NSTEPS;

    pva_pkg::coord_t x_reg [N+1];
    pva_pkg::coord_t y_reg [N+1];
    pva_pkg::angle_t z_reg [N+1];
    logic [N:0]      zero_reg;
    pva_pkg::coord_t sx, sy;
    logic [66:0]     prod_reg;
    pva_pkg::angle_t zf_reg;
    logic            zf_zero_reg;
    logic [16:0]     rad_reg;
    logic signed [15:0] ang_reg;

    logic [21:0]        rad_full;
    pva_pkg::angle_t    zr;
    logic signed [16:0] ang_full;

    // The lanes' results merge here and the sum is folded into the right half-plane.
    always_comb
    begin
        sx = x1 + x2;
        sy = y1 + y2;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            zero_reg[0] <= (sx == '0) && (sy == '0);
            if (sx < 0 && sy >= 0)
            begin
                x_reg[0] <= sy;
                y_reg[0] <= -sx;
                z_reg[0] <= pva_pkg::QUARTER_Q16;
            end
            else if (sx < 0)
            begin
                x_reg[0] <= -sy;
                y_reg[0] <= sx;
                z_reg[0] <= -pva_pkg::QUARTER_Q16;
            end
            else
            begin
                x_reg[0] <= sx;
                y_reg[0] <= sy;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en[i+1])
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i][pva_pkg::CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - pva_pkg::atan_deg(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + pva_pkg::atan_deg(i);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[N+1])
        begin
            if (x_reg[N][pva_pkg::CW-1])
                prod_reg <= '0;
            else
                prod_reg <= 67'(x_reg[N][pva_pkg::CW-2:0]) * 67'(pva_pkg::GAIN_Q31);
            zf_reg      <= z_reg[N];
            zf_zero_reg <= zero_reg[N];
        end
    end

    always_comb
    begin
        rad_full = 22'((prod_reg + (67'd1 << 44)) >> 45);
        zr       = zf_reg + pva_pkg::angle_t'(256);
        ang_full = 17'(zr >>> 9);
    end

    always_ff @(posedge clk)
    begin
        if (en[N+2])
        begin
            if (zf_zero_reg)
            begin
                rad_reg <= '0;
                ang_reg <= '0;
            end
            else
            begin
                rad_reg <= (rad_full > 22'd131071) ? 17'h1FFFF : rad_full[16:0];
                if (ang_full > 17'sd23040)
                    ang_reg <= 16'sd23040;
                else if (ang_full < -17'sd23040)
                    ang_reg <= -16'sd23040;
                else
                    ang_reg <= ang_full[15:0];
            end
        end
    end

    assign sum_radius = rad_reg;
    assign sum_angle  = ang_reg;

endmodule

// File: tb/tb_polar_vector_add_unit.sv
module tb_polar_vector_add_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 2 * pva_pkg::NSTEPS + 5;
    localparam int N_RANDOM    = 1700;
    localparam int IDLE_LIMIT  = 20000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic [15:0] radius;
        logic [15:0] angle;
    } polar_in_t;

    typedef struct packed {
        logic [16:0] radius;
        logic [15:0] angle;
    } polar_sum_t;

    typedef struct {
        polar_in_t  first;
        polar_in_t  second;
        logic       has_expected;
        polar_sum_t expected;
    } vector_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    polar_sum_t  sum_queue[$];
    polar_in_t   pending_first[$];
    polar_in_t   pending_second[$];
    logic        pending_has[$];
    polar_sum_t  pending_sum[$];
    int          mismatch_count;
    int          idle_cycles;
    bit          timed_out;
    bit          stimulus_done;
    bit          long_hold_req;
    bit          long_hold_done;

    polar_vector_add_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic longint shift_right_signed(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_entry(int i);
        longint table_deg[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                  58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                  229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        return table_deg[i];
    endfunction

    function automatic int step_total();
        return (pva_pkg::CORDIC_STEPS > 24) ? 24 : pva_pkg::CORDIC_STEPS;
    endfunction

    // Rotation CORDIC: polar input to rectangular with 22 fraction bits.
    function automatic void rect_from_polar(input polar_in_t v, output longint xo,
                                            output longint yo);
        longint r;
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        r = longint'((64'(v.radius) * 64'd1304065748) >> 17);
        a = longint'($signed(v.angle));
        if (a > 23040)
            a -= 46080;
        else if (a < -23040)
            a += 46080;
        z = a * 512;
        if (z > 5898240)
        begin
            x = 0; y = r; z -= 5898240;
        end
        else if (z < -5898240)
        begin
            x = 0; y = -r; z += 5898240;
        end
        else
        begin
            x = r; y = 0;
        end
        for (int i = 0; i < step_total(); i++)
        begin
            dx = shift_right_signed(y, i);
            dy = shift_right_signed(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_entry(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_entry(i);
            end
        end
        xo = x;
        yo = y;
    endfunction

    function automatic polar_sum_t predict_polar_sum(polar_in_t p, polar_in_t q);
        longint     x1, y1, x2, y2, x, y, z, t, dx, dy, ang;
        logic [63:0] rad;
        polar_sum_t res;
        rect_from_polar(p, x1, y1);
        rect_from_polar(q, x2, y2);
        x = x1 + x2;
        y = y1 + y2;
        if (x == 0 && y == 0)
            return '0;
        z = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 5898240;
            end
            else
            begin
                x = -y; y = t; z = -5898240;
            end
        end
        for (int i = 0; i < step_total(); i++)
        begin
            dx = shift_right_signed(y, i);
            dy = shift_right_signed(x, i);
            if (y < 0)
            begin
                x -= dx; y += dy; z -= atan_entry(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_entry(i);
            end
        end
        if (x < 0)
            x = 0;
        rad = (64'(x) * 64'd1304065748 + (64'd1 << 44)) >> 45;
        if (rad > 64'd131071)
            rad = 64'd131071;
        ang = shift_right_signed(z + 256, 9);
        if (ang > 23040)
            ang = 23040;
        else if (ang < -23040)
            ang = -23040;
        res.radius = rad[16:0];
        res.angle  = ang[15:0];
        return res;
    endfunction

    function automatic polar_in_t polar(int r, int a);
        polar_in_t v;
        v.radius = r[15:0];
        v.angle  = a[15:0];
        return v;
    endfunction

    function automatic logic [15:0] random_angle();
        // Mostly legal angles, sometimes any 16-bit pattern.
        if ($urandom_range(7) == 0)
            return 16'($urandom);
        return 16'($urandom_range(46080) - 23040);
    endfunction

    function automatic logic [15:0] random_radius();
        case ($urandom_range(3))
            0: return 16'($urandom_range(255));
            1: return 16'hFFFF - 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_request(polar_in_t p, polar_in_t q, logic has, polar_sum_t e);
        pending_first.push_back(p);
        pending_second.push_back(q);
        pending_has.push_back(has);
        pending_sum.push_back(e);
    endtask

    task automatic build_stimulus();
        vector_row_t rows[$];
        vector_row_t row;
        polar_in_t   p;
        polar_in_t   q;
        rows.push_back('{polar(0, 0), polar(0, 0), 1'b1, '0});
        rows.push_back('{polar(0, 23040), polar(0, -23040), 1'b1, '0});
        rows.push_back('{polar(256, 0), polar(256, 23040), 1'b0, '0});
        rows.push_back('{polar(65535, 0), polar(65535, 0), 1'b0, '0});
        rows.push_back('{polar(65535, 11520), polar(65535, 11520), 1'b0, '0});
        rows.push_back('{polar(256, 23040), polar(0, 0), 1'b0, '0});
        rows.push_back('{polar(256, -23040), polar(0, 0), 1'b0, '0});
        rows.push_back('{polar(256, 32767), polar(256, -32768), 1'b0, '0});
        rows.push_back('{polar(100, 11521), polar(100, -11521), 1'b0, '0});
        rows.push_back('{polar(100, 23039), polar(100, -23039), 1'b0, '0});
        rows.push_back('{polar(65535, 23040), polar(1, 0), 1'b0, '0});
        rows.push_back('{polar(1, 0), polar(1, 0), 1'b0, '0});
        rows.push_back('{polar(40000, 5000), polar(30000, -7000), 1'b0, '0});
        rows.push_back('{polar(256, -11520), polar(0, 0), 1'b0, '0});
        rows.push_back('{polar(256, 11520), polar(256, -11520), 1'b0, '0});
        rows.push_back('{polar(32768, -1), polar(32767, 65535), 1'b0, '0});
        foreach (rows[i])
        begin
            row = rows[i];
            queue_request(row.first, row.second, row.has_expected, row.expected);
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            p.radius = random_radius();
            p.angle  = random_angle();
            if ($urandom_range(9) == 0)
            begin
                // Opposite vectors of equal length, to probe near-zero sums.
                q.radius = p.radius;
                q.angle  = ($signed(p.angle) > 0) ? p.angle - 16'd23040 : p.angle + 16'd23040;
            end
            else
            begin
                q.radius = random_radius();
                q.angle  = random_angle();
            end
            queue_request(p, q, 1'b0, '0);
        end
    endtask

    initial
    begin
        int burst;
        polar_in_t  p;
        polar_in_t  q;
        polar_sum_t e;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        stimulus_done  = 1'b0;
        long_hold_req  = 1'b0;
        build_stimulus();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_first.size() > 0)
        begin
            burst = $urandom_range(40, 1);
            if (pending_first.size() <= N_RANDOM / 2)
                long_hold_req = 1'b1;
            while (burst > 0 && pending_first.size() > 0)
            begin
                p = pending_first.pop_front();
                q = pending_second.pop_front();
                e = pending_sum.pop_front();
                if (!pending_has.pop_front())
                    e = predict_polar_sum(p, q);
                s_tvalid <= 1'b1;
                s_tdata  <= {q.angle, q.radius, p.angle, p.radius};
                @(posedge clk);
                while (!s_tready)
                    @(posedge clk);
                sum_queue.push_back(e);
                burst--;
            end
            if ($urandom_range(3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Receiver: stalls on its own pattern; one long hold-off lets the pipeline fill.
    initial
    begin
        int mode;
        m_tready       = 1'b0;
        long_hold_done = 1'b0;
        mode           = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if ($urandom_range(63) == 0)
                mode = $urandom_range(2);
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(3) != 0);
                default: m_tready <= ($urandom_range(3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        polar_sum_t got;
        polar_sum_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.radius = m_tdata[16:0];
            got.angle  = m_tdata[32:17];
            if (sum_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result radius=%0d angle=%0d",
                             got.radius, $signed(got.angle));
            end
            else
            begin
                want = sum_queue.pop_front();
                if (got.radius !== want.radius || got.angle !== want.angle
                    || m_tdata[39:33] !== 7'd0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: radius exp %0d got %0d, angle exp %0d got %0d",
                                 want.radius, got.radius,
                                 $signed(want.angle), $signed(got.angle));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        timed_out      = 1'b0;
        @(posedge rst_n);
        while (!(stimulus_done && sum_queue.size() == 0) && !timed_out)
        begin
            @(posedge clk);
            if (idle_cycles >= IDLE_LIMIT)
                timed_out = 1'b1;
        end
        if (timed_out)
        begin
            $display("Test completed with failures");
        end
        else
        begin
            repeat (2 * LATENCY) @(posedge clk);
            if (mismatch_count == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: polar_vector_add_unit.f
rtl/pva_pkg.sv
rtl/pva_rect_lane.sv
rtl/pva_polar_merge.sv
rtl/polar_vector_add_unit.sv
tb/tb_polar_vector_add_unit.sv
